[rtl/haversine_distance_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the haversine distance block.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define HVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[rtl/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Constants, fixed-point tables and elaboration-time helpers for the
// haversine distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int ANG_F         = 30;             // fraction bits of angles
  localparam int CORDIC_STAGES = 24;
  localparam int ANG_W         = ANG_F + 4;      // signed Q2.F with headroom
  localparam int MAG_W         = ANG_F + 2;      // magnitude of a trig value
  localparam int SQRT_STEPS    = ANG_F + 2;
  localparam int REM_W         = 2 * ANG_F + 1;
  localparam int CFG_W         = 20;
  localparam int DIST_W        = 21;
  localparam int LATENCY       = 2 * CORDIC_STAGES + SQRT_STEPS + 9;

  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [63:0] UNITS_PER_PI = 64'd64800000;
  localparam logic [63:0] RAD_PER_UNIT =
      ((PI_Q60 / UNITS_PER_PI) << 20) + (((PI_Q60 % UNITS_PER_PI) << 20) / UNITS_PER_PI);
  localparam int SH_HALF = 81 - ANG_F;
  localparam int SH_FULL = 80 - ANG_F;

  localparam logic signed [ANG_W-1:0] PI_Q =
      ANG_W'((PI_Q60 + (64'd1 << (59 - ANG_F))) >> (60 - ANG_F));
  localparam logic signed [ANG_W-1:0] HALF_PI =
      ANG_W'((PI_Q60 + (64'd1 << (60 - ANG_F))) >> (61 - ANG_F));
  localparam logic [ANG_F:0]       ONE_Q    = (ANG_F + 1)'(64'd1 << ANG_F);
  localparam logic [63:0]          RND_MUL  = 64'd1 << (ANG_F - 1);

  localparam logic [CFG_W-1:0]  RADIUS_RESET = 20'd637101;
  localparam logic [DIST_W-1:0] DIST_MAX     = 21'd2097151;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    int i;
    rem = '0;
    q   = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) from its series, rounded to Q2.F
  function automatic logic signed [ANG_W-1:0] atan_stage(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    logic        stop;
    int k;
    int s;
    acc  = '0;
    stop = 1'b0;
    if (i == 0) begin
      acc = PI_Q60;
    end else begin
      for (k = 0; k < 32; k++) begin
        s = i * (2 * k + 1);
        if (s > 62) stop = 1'b1;
        if (!stop) begin
          term = udiv64(64'd1 << (62 - s), 64'(2 * k + 1));
          if (k[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return ANG_W'((acc + (64'd1 << (61 - ANG_F))) >> (62 - ANG_F));
  endfunction

  function automatic logic [63:0] sqrt_wide(input logic [63:0] a);
    logic [127:0] t;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  c;
    int b;
    r = '0;
    t = {64'd0, a} << ANG_F;
    for (b = ANG_F + 1; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= t) r = c;
    end
    return r;
  endfunction

  // inverse CORDIC gain
  function automatic logic [63:0] gain_inverse();
    logic [63:0] p;
    logic [63:0] g;
    logic [63:0] rem;
    logic [63:0] q;
    int i;
    p = 64'd1 << ANG_F;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 63) p = p + (p >> (2 * i));
    end
    g   = sqrt_wide(p);
    rem = 64'd1 << ANG_F;
    q   = '0;
    for (i = 0; i < ANG_F; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= g) begin
        rem  = rem - g;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic signed [ANG_W-1:0] KINV = ANG_W'(gain_inverse());

  function automatic logic [MAG_W-1:0] mag(input logic signed [ANG_W-1:0] v);
    return (v < 0) ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

[rtl/haversine_distance.sv]
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points, haversine form, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   | handshake             | word
//  ----------+-----------------------+-----------------------------------------
//  command   | start / busy          | first/second latitude and longitude
//  result    | done (strobe)         | distance, hundredths of a km, saturated
//  config    | cfg_valid / cfg_ready | cfg_data: sphere radius, tens of metres
//
//  One word enters per clock; busy stays low. The pipeline depth is set
//  by the two 24-stage CORDIC chains and the 32-step square root, one
//  iteration per stage.
//  rst (synchronous) drops every word in flight and restores the radius.
//  The result side has no back pressure, so the pipeline never stalls.
//
//  Flow: angle scaling (partial products, then round), reduction by pi,
//  rotation CORDIC for sin(dlat/2), sin(dlon/2), cos(lat1), cos(lat2),
//  haversine term with clamping, two bitwise square roots, vectoring
//  CORDIC for the half central angle, then scaling by twice the radius.
// ----------------------------------------------------------------------------
module haversine_distance import hvd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [25:0]       first_latitude,
  input  logic signed [26:0]       first_longitude,
  input  logic signed [25:0]       second_latitude,
  input  logic signed [26:0]       second_longitude,
  output logic                     done,
  output logic [DIST_W-1:0]        distance,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int NS = CORDIC_STAGES;

  logic [CFG_W-1:0] radius;
  logic [LATENCY:1] vld;
  logic             accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign done      = vld[LATENCY];

  // Hold the radius until a config word arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  // Valid flags advance alongside the data, one stage per clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-1:1], accept};
    end
  end

  // Stage 1: latitude and longitude differences, plus the raw latitudes.
  // Slots: 0 = dlat, 1 = dlon (both halved later), 2 = lat1, 3 = lat2.
  logic signed [27:0] ang_in [4];

  always_ff @(posedge clk) begin
    ang_in[0] <= 28'(second_latitude) - 28'(first_latitude);
    ang_in[1] <= 28'(second_longitude) - 28'(first_longitude);
    ang_in[2] <= 28'(first_latitude);
    ang_in[3] <= 28'(second_latitude);
  end

  // Stage 2: magnitude times radians-per-unit, split into two partial products.
  logic [59:0] ph [4];
  logic [59:0] pl [4];
  logic        sgn [4];

  // Stage 3: round the product to a Q2.F angle.
  logic signed [ANG_W-1:0] theta [4];

  // Stage 4 and the rotation CORDIC.
  logic signed [ANG_W-1:0] cx [4][NS+1];
  logic signed [ANG_W-1:0] cy [4][NS+1];
  logic signed [ANG_W-1:0] cz [4][NS+1];
  logic                    rneg [4][NS+1];

  for (genvar ch = 0; ch < 4; ch++) begin : g_angle
    localparam int SH = (ch < 2) ? SH_HALF : SH_FULL;
    logic [27:0]      amag;
    logic [95:0]      sum;
    logic [ANG_W-1:0] m;

    assign amag = ang_in[ch][27] ? 28'(-ang_in[ch]) : 28'(ang_in[ch]);

    always_ff @(posedge clk) begin
      ph[ch]  <= 60'(amag) * 60'(RAD_PER_UNIT[63:32]);
      pl[ch]  <= 60'(amag) * 60'(RAD_PER_UNIT[31:0]);
      sgn[ch] <= ang_in[ch][27];
    end

    // Round half away from zero on the magnitude, then restore the sign.
    assign sum = ({36'd0, ph[ch]} << 32) + 96'(pl[ch]) + (96'd1 << (SH - 1));
    assign m   = ANG_W'(sum >> SH);

    always_ff @(posedge clk) begin
      theta[ch] <= sgn[ch] ? -$signed(m) : $signed(m);
    end

    // Fold the angle into +-pi/2 and remember to negate the result.
    always_ff @(posedge clk) begin
      cx[ch][0] <= KINV;
      cy[ch][0] <= '0;
      if (theta[ch] > HALF_PI) begin
        cz[ch][0]   <= theta[ch] - PI_Q;
        rneg[ch][0] <= 1'b1;
      end else if (theta[ch] < -HALF_PI) begin
        cz[ch][0]   <= theta[ch] + PI_Q;
        rneg[ch][0] <= 1'b1;
      end else begin
        cz[ch][0]   <= theta[ch];
        rneg[ch][0] <= 1'b0;
      end
    end

    for (genvar i = 0; i < NS; i++) begin : g_rot
      localparam logic signed [ANG_W-1:0] ATAN_I = atan_stage(i);
      always_ff @(posedge clk) begin
        rneg[ch][i+1] <= rneg[ch][i];
        if (cz[ch][i] >= 0) begin
          cx[ch][i+1] <= cx[ch][i] - (cy[ch][i] >>> i);
          cy[ch][i+1] <= cy[ch][i] + (cx[ch][i] >>> i);
          cz[ch][i+1] <= cz[ch][i] - ATAN_I;
        end else begin
          cx[ch][i+1] <= cx[ch][i] + (cy[ch][i] >>> i);
          cy[ch][i+1] <= cy[ch][i] - (cx[ch][i] >>> i);
          cz[ch][i+1] <= cz[ch][i] + ATAN_I;
        end
      end
    end
  end

  // Haversine term: h = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2).
  // Squares ignore the fold sign; the cosine product takes both.
  logic [MAG_W-1:0]   s11;
  logic [MAG_W-1:0]   s22;
  logic [MAG_W-1:0]   cc_mag;
  logic               cc_neg;
  logic [MAG_W-1:0]   s11_d;
  logic [MAG_W:0]     t_mag;
  logic               t_neg;
  logic [2*MAG_W-1:0] p_s1;
  logic [2*MAG_W-1:0] p_s2;
  logic [2*MAG_W-1:0] p_cc;
  logic [2*MAG_W-1:0] p_t;

  assign p_s1 = mag(cy[0][NS]) * mag(cy[0][NS]);
  assign p_s2 = mag(cy[1][NS]) * mag(cy[1][NS]);
  assign p_cc = mag(cx[2][NS]) * mag(cx[3][NS]);
  assign p_t  = cc_mag * s22;

  always_ff @(posedge clk) begin
    s11    <= MAG_W'((p_s1 + RND_MUL) >> ANG_F);
    s22    <= MAG_W'((p_s2 + RND_MUL) >> ANG_F);
    cc_mag <= MAG_W'((p_cc + RND_MUL) >> ANG_F);
    cc_neg <= (cx[2][NS] < 0) ^ rneg[2][NS] ^ (cx[3][NS] < 0) ^ rneg[3][NS];
    s11_d  <= s11;
    t_mag  <= (MAG_W + 1)'((p_t + RND_MUL) >> ANG_F);
    t_neg  <= cc_neg;
  end

  // Clamp h to [0, 1] and seed both square roots with h and 1 - h.
  logic signed [MAG_W+2:0] hs;
  logic [ANG_F:0]          h;

  logic [MAG_W-1:0] sq_r   [2][SQRT_STEPS+1];
  logic [REM_W-1:0] sq_rem [2][SQRT_STEPS+1];

  always_comb begin
    hs = t_neg ? $signed({3'b0, s11_d}) - $signed({2'b0, t_mag})
               : $signed({3'b0, s11_d}) + $signed({2'b0, t_mag});
    if (hs < 0) begin
      h = '0;
    end else if (hs > $signed((MAG_W + 3)'(ONE_Q))) begin
      h = ONE_Q;
    end else begin
      h = (ANG_F + 1)'(hs);
    end
  end

  always_ff @(posedge clk) begin
    sq_r[0][0]   <= '0;
    sq_r[1][0]   <= '0;
    sq_rem[0][0] <= {h, {ANG_F{1'b0}}};
    sq_rem[1][0] <= {ONE_Q - h, {ANG_F{1'b0}}};
  end

  // Bitwise root: keep rem = a - r^2 and try one result bit per stage.
  for (genvar k = 0; k < 2; k++) begin : g_sqrt
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam int B = SQRT_STEPS - 1 - j;
      logic [2*MAG_W-1:0] trial;
      assign trial = ((2*MAG_W)'(sq_r[k][j]) << (B + 1)) | ((2*MAG_W)'(1) << (2 * B));
      always_ff @(posedge clk) begin
        if (trial <= (2*MAG_W)'(sq_rem[k][j])) begin
          sq_rem[k][j+1] <= sq_rem[k][j] - REM_W'(trial);
          sq_r[k][j+1]   <= sq_r[k][j] | (MAG_W'(1) << B);
        end else begin
          sq_rem[k][j+1] <= sq_rem[k][j];
          sq_r[k][j+1]   <= sq_r[k][j];
        end
      end
    end
  end

  // Vectoring CORDIC: z = atan(sqrt(h) / sqrt(1 - h)), the half central angle.
  logic signed [ANG_W-1:0] vx [1:NS];
  logic signed [ANG_W-1:0] vy [1:NS];
  logic signed [ANG_W-1:0] vz [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_vec
    localparam logic signed [ANG_W-1:0] ATAN_I = atan_stage(i);
    logic signed [ANG_W-1:0] xi;
    logic signed [ANG_W-1:0] yi;
    logic signed [ANG_W-1:0] zi;
    if (i == 0) begin : g_first
      assign xi = $signed(ANG_W'(sq_r[1][SQRT_STEPS]));
      assign yi = $signed(ANG_W'(sq_r[0][SQRT_STEPS]));
      assign zi = '0;
    end else begin : g_next
      assign xi = vx[i];
      assign yi = vy[i];
      assign zi = vz[i];
    end
    always_ff @(posedge clk) begin
      if (yi >= 0) begin
        vx[i+1] <= xi + (yi >>> i);
        vy[i+1] <= yi - (xi >>> i);
        vz[i+1] <= zi + ATAN_I;
      end else begin
        vx[i+1] <= xi - (yi >>> i);
        vy[i+1] <= yi + (xi >>> i);
        vz[i+1] <= zi - ATAN_I;
      end
    end
  end

  // Distance = round(2 * R * z), saturated to the output range.
  logic [MAG_W-1:0]       zc;
  logic [CFG_W+MAG_W-1:0] prod;
  logic [CFG_W+MAG_W-1:0] dsum;

  assign zc   = (vz[NS] < 0) ? '0 : MAG_W'(vz[NS]);
  assign dsum = (prod + ((CFG_W + MAG_W)'(1) << (ANG_F - 2))) >> (ANG_F - 1);

  always_ff @(posedge clk) begin
    prod     <= radius * zc;
    distance <= (dsum > (CFG_W + MAG_W)'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsum);
  end

  // Unused outputs of the CORDIC chains (cosines of half differences,
  // sines of latitudes, residual angles) are simply left to synthesis.

endmodule

[rtl/hvd_checker.sv]
// ----------------------------------------------------------------------------
// hvd_checker
// Port-level checks on the haversine distance pipeline, bound to the top.
// ----------------------------------------------------------------------------
`include "haversine_distance_macros.svh"

module hvd_checker import hvd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Every accepted command yields exactly one strobe, and no strobe comes without a command.
  `HVD_ASSERT(a_latency, (start && !busy) |-> ##LATENCY done, "result strobe missing")
  `HVD_ASSERT(a_no_orphan, done |-> $past(start && !busy, LATENCY), "result without command")
  // Reset drops every word in flight.
  `HVD_ASSERT_ALWAYS(a_reset_flush, rst |=> !done, "result strobe after reset")

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: haversine distance testbench
// Streams coordinate pairs into the pipeline and predicts each distance
// with a fixed-point model of its own. Results are checked in order
// against the radius set at the time. Several radius settings are covered.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hvd_pkg::*;

  localparam int FB        = 30;     // angle fraction bits
  localparam int STAGES    = 24;
  localparam int DRAIN     = 120;    // cycles to let the pipe empty
  localparam int STALL_MAX = 4000;   // cycles with no traffic before giving up

  // Keep the expected distances and the fixed-point predictor in one place.
  class distance_board;
    logic [DIST_W-1:0] pending[$];
    logic [CFG_W-1:0]  radius;
    int                errors;
    longint            atan_tab[STAGES];
    longint            kinv;
    longint            rad_per_unit;
    longint            pi_q;
    longint            half_pi;

    function new();
      longint unsigned pi60;
      pi60         = 64'h3243F6A8885A308D;
      radius       = 20'd637101;
      errors       = 0;
      rad_per_unit = ((pi60 / 64800000) << 20) + (((pi60 % 64800000) << 20) / 64800000);
      pi_q         = (pi60 + (64'd1 << (59 - FB))) >> (60 - FB);
      half_pi      = (pi60 + (64'd1 << (60 - FB))) >> (61 - FB);
      for (int i = 0; i < STAGES; i++) atan_tab[i] = arctan_step(i);
      kinv = inverse_gain();
    endfunction

    // round(a*b / 2^sh) half away from zero on the magnitude
    function longint mul_rnd(longint a, longint b, int sh);
      logic          neg;
      logic [127:0]  prod;
      logic [63:0]   m;
      neg  = (a < 0) != (b < 0);
      prod = 128'(64'(a < 0 ? -a : a)) * 128'(64'(b < 0 ? -b : b));
      prod = prod + (128'd1 << (sh - 1));
      m    = 64'(prod >> sh) & 64'h3FFFFFFFFFFFFFFF;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint arctan_step(int i);
      longint unsigned acc;
      longint unsigned s;
      acc = 0;
      if (i == 0) begin
        acc = 64'h3243F6A8885A308D;
      end else begin
        for (int k = 0; k < 64; k++) begin
          s = i * (2 * k + 1);
          if (s > 62) break;
          if (k % 2) acc -= (64'd1 << (62 - s)) / (2 * k + 1);
          else acc += (64'd1 << (62 - s)) / (2 * k + 1);
        end
      end
      return (acc + (64'd1 << (61 - FB))) >> (62 - FB);
    endfunction

    function longint root_q(longint a);
      logic [127:0] target;
      logic [63:0]  r;
      logic [63:0]  c;
      r = 0;
      if (a <= 0) return 0;
      target = 128'(a) << FB;
      for (int b = FB + 1; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= target) r = c;
      end
      return r;
    endfunction

    function longint inverse_gain();
      longint p;
      longint g;
      longint rem;
      longint q;
      p = longint'(1) << FB;
      for (int i = 0; i < STAGES; i++) if (2 * i < 63) p += p >>> (2 * i);
      g   = root_q(p);
      rem = longint'(1) << FB;
      q   = 0;
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= g) begin
          rem -= g;
          q |= 1;
        end
      end
      return q;
    endfunction

    // rotate (kinv, 0) by th; fold once by pi into the CORDIC's reach
    function void rotate(longint th, output longint s, output longint c);
      longint x, y, z, nx;
      logic   flip;
      x = kinv; y = 0; z = th; flip = 0;
      if (z > half_pi) begin
        z -= pi_q; flip = 1;
      end else if (z < -half_pi) begin
        z += pi_q; flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint vector_angle(longint y, longint x);
      longint z, nx;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end else begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end
        x = nx;
      end
      return z;
    endfunction

    function logic [DIST_W-1:0] great_circle(longint lat1, longint lon1,
                                             longint lat2, longint lon2);
      longint hdlat, hdlon, a1, a2, s1, s2, c1, c2, junk, h, z;
      longint unsigned d;
      hdlat = mul_rnd(lat2 - lat1, rad_per_unit, 81 - FB);
      hdlon = mul_rnd(lon2 - lon1, rad_per_unit, 81 - FB);
      a1    = mul_rnd(lat1, rad_per_unit, 80 - FB);
      a2    = mul_rnd(lat2, rad_per_unit, 80 - FB);
      rotate(hdlat, s1, junk);
      rotate(hdlon, s2, junk);
      rotate(a1, junk, c1);
      rotate(a2, junk, c2);
      h = mul_rnd(s1, s1, FB) + mul_rnd(mul_rnd(c1, c2, FB), mul_rnd(s2, s2, FB), FB);
      if (h < 0) h = 0;
      if (h > (longint'(1) << FB)) h = longint'(1) << FB;
      z = vector_angle(root_q(h), root_q((longint'(1) << FB) - h));
      if (z < 0) z = 0;
      d = (2 * longint'(radius) * z + (longint'(1) << (FB - 1))) >> FB;
      if (d > 2097151) d = 2097151;
      return d[DIST_W-1:0];
    endfunction

    // note an accepted coordinate word
    function void note_pair(logic signed [25:0] la1, logic signed [26:0] lo1,
                            logic signed [25:0] la2, logic signed [26:0] lo2);
      pending.push_back(great_circle(la1, lo1, la2, lo2));
    endfunction

    function void check_distance(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t distance with nothing pending: expected none actual %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t distance: expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [25:0]       first_latitude;
  logic signed [26:0]       first_longitude;
  logic signed [25:0]       second_latitude;
  logic signed [26:0]       second_longitude;
  logic                     done;
  logic [DIST_W-1:0]        distance;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data;

  distance_board board;
  int            quiet_cycles;

  haversine_distance dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .first_latitude   (first_latitude),
    .first_longitude  (first_longitude),
    .second_latitude  (second_latitude),
    .second_longitude (second_longitude),
    .done             (done),
    .distance         (distance),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Check every result word the moment its strobe is seen.
  always @(posedge clk) begin
    if (!rst && done) board.check_distance(distance);
  end

  // Watchdog: reset the count whenever any word moves in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("haversine_distance: mismatch");
        $finish;
      end
    end
  end

  // Present one command word and hold it until the edge that takes it.
  task automatic send_pair(input logic signed [25:0] la1, input logic signed [26:0] lo1,
                           input logic signed [25:0] la2, input logic signed [26:0] lo2);
    start            <= 1'b1;
    first_latitude   <= la1;
    first_longitude  <= lo1;
    second_latitude  <= la2;
    second_longitude <= lo2;
    do @(posedge clk); while (busy);
    board.note_pair(la1, lo1, la2, lo2);
  endtask

  // Drop start for a while; the gap length is the caller's choice.
  task automatic idle_cycles(input int n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until the pipeline has emptied out.
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write the radius register; only called with the pipe empty.
  task automatic set_radius(input logic [CFG_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    board.radius = r;
    cfg_valid <= 1'b0;
  endtask

  // Build one random pair: mostly in range, some close neighbours, some raw bits.
  task automatic random_pair();
    logic signed [25:0] la1, la2;
    logic signed [26:0] lo1, lo2;
    int                 pick;
    pick = $urandom_range(99);
    la1 = 26'($signed($urandom_range(64800000)) - 32400000);
    lo1 = 27'($signed($urandom_range(129600000)) - 64800000);
    if (pick < 20) begin
      la2 = 26'(la1 + $signed($urandom_range(20000)) - 10000);
      lo2 = 27'(lo1 + $signed($urandom_range(20000)) - 10000);
    end else if (pick < 30) begin
      la1 = 26'($urandom); lo1 = 27'($urandom);
      la2 = 26'($urandom); lo2 = 27'($urandom);
    end else begin
      la2 = 26'($signed($urandom_range(64800000)) - 32400000);
      lo2 = 27'($signed($urandom_range(129600000)) - 64800000);
    end
    send_pair(la1, lo1, la2, lo2);
  endtask

  localparam logic signed [25:0] LAT_MAX = 26'sd32400000;
  localparam logic signed [26:0] LON_MAX = 27'sd64800000;

  logic [CFG_W-1:0] radii[6];
  int               burst;

  initial begin
    board        = new();
    rst          = 1'b1;
    start        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    first_latitude   = '0;
    first_longitude  = '0;
    second_latitude  = '0;
    second_longitude = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: same point, poles, antipodes, range edges, beyond-pole latitudes,
    // wrapped longitudes and the raw extremes of each field.
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(16200000, 32400000, -16200000, -32400000);
    send_pair(26'sh1FFFFFF, 27'sh3FFFFFF, 26'sh2000000, 27'sh4000000);
    send_pair(26'sh2000000, 27'sh4000000, 26'sh1FFFFFF, 27'sh3FFFFFF);
    send_pair(26'sh2000000, 0, 26'sh2000000, 27'sh4000000);
    send_pair(LAT_MAX + 26'sd1000, 0, LAT_MAX - 26'sd1000, 100);
    send_pair(1, 0, 0, 1);
    send_pair(0, 0, 1, 0);
    send_pair(-1, -1, 1, 1);
    send_pair(18306000, -266400, 14670000, 1008000);
    send_pair(0, 0, 0, 27'sd64799999);
    send_pair(26'sd5, 27'sd0, 26'sd5, 27'sd0);
    send_pair(26'sd32000000, 27'sd100, -26'sd32000000, -27'sd64799900);
    send_pair(26'sd3, 27'sd2, 26'sd1, 27'sd7);
    drain();

    // Radius settings: reset value, extremes of the range and the field, zero.
    radii[0] = 20'd1;
    radii[1] = 20'd650000;
    radii[2] = 20'd0;
    radii[3] = 20'hFFFFF;
    radii[4] = 20'($urandom_range(650000, 1));
    radii[5] = 20'd637101;

    foreach (radii[p]) begin
      set_radius(radii[p]);
      send_pair(0, -LON_MAX, 0, LON_MAX);
      for (int n = 0; n < 190; ) begin
        burst = $urandom_range(40, 1);
        for (int b = 0; b < burst && n < 190; b++, n++) begin
          random_pair();
          if (p == 3 && n == 90) drain();
        end
        if ($urandom_range(3) != 0) idle_cycles($urandom_range(12));
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("haversine_distance: match");
    end else begin
      $display("haversine_distance: mismatch");
    end
    $finish;
  end
endmodule
